>>> src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, widths and codes for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int TOTAL_W        = 11;
    localparam int BSIZE_W        = 13;
    localparam int START_W        = 10;
    localparam int COUNT_W        = 11;
    localparam int RUN_W          = 10;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_RST = 11'd1024;
    localparam logic [BSIZE_W-1:0] BSIZE_RST = 13'd512;

    typedef enum logic [1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NORUN = 2'd2
    } status_t;

    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_BSIZE = 1'b1;

endpackage

>>> src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit free-space bitmap: format, allocate, free and find over a map
// held in one word-wide memory.
// Allocate and free read and write back each map word in the range; format
// runs the divider and then writes every map word; find reads each map word
// and scans it, 4 bits checked per cycle. Out-of-range and empty requests
// finish without touching the map. One item at a time. After reset a clearing
// pass over every map word holds busy high.
// Each result beat is shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [START_W-1:0] start_block,
    input  logic [COUNT_W-1:0] block_count,
    output logic               done,
    output logic [1:0]         status,
    output logic               found,
    output logic [RUN_W-1:0]   run_start
);

    localparam int WORD_W = (NUM_BLOCKS < 32) ? 8 : 32;
    localparam int DEPTH  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OB     = $clog2(WORD_W);
    localparam int IW     = ($clog2(NUM_BLOCKS) + 2 > 12) ? $clog2(NUM_BLOCKS) + 2 : 12;
    localparam int STEP   = 4;
    localparam int NSTEP  = WORD_W / STEP;
    localparam int JW     = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIV   = 8'b0000_0010,
        S_FMT   = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_FRD   = 8'b0010_0000,
        S_FLD   = 8'b0100_0000,
        S_FSCAN = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [BSIZE_W-1:0] bsize_reg;
    logic               set_reg, set_next;
    logic               report_reg, report_next;
    logic [IW-1:0]      first_reg, first_next;
    logic [IW-1:0]      end_reg, end_next;
    logic [IW-1:0]      count_reg, count_next;
    logic [IW-1:0]      usable_reg, usable_next;
    logic [IW-1:0]      reserve_reg, reserve_next;
    logic [IW-1:0]      len_reg, len_next;
    logic [AW-1:0]      w_reg, w_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [JW-1:0]      j_reg, j_next;
    logic [WORD_W-1:0]  word_reg;
    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic               found_reg, found_next;
    logic [RUN_W-1:0]   run_reg, run_next;

    logic               accept;
    logic               cfg_wr;
    logic [IW-1:0]      usable_now;
    logic [IW-1:0]      base;
    logic [IW-1:0]      reserve_calc;
    logic               mem_we;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  mem_rdata;
    logic               div_go;
    logic               div_done;
    logic [TOTAL_W-1:0] div_q;
    logic [IW-1:0]      idx;
    logic [IW-1:0]      len_scan;
    logic               hit;
    logic               stop;
    logic [IW-1:0]      hit_run;

    assign accept = start && (state_reg == S_IDLE);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RST;
            bsize_reg <= BSIZE_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_TOTAL)
            begin
                total_reg <= pwdata[TOTAL_W-1:0];
            end
            else
            begin
                bsize_reg <= pwdata[BSIZE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_BSIZE) ? PDATA_W'(bsize_reg) : PDATA_W'(total_reg);

    assign usable_now = (IW'(total_reg) > IW'(NUM_BLOCKS)) ? IW'(NUM_BLOCKS) : IW'(total_reg);
    assign base       = IW'(w_reg) << OB;
    assign div_go     = accept && (operation == OP_FORMAT);

    bba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (total_reg),
        .divisor  (bsize_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        reserve_calc = IW'(div_q) + IW'(2);
        if (reserve_calc > usable_reg)
        begin
            reserve_calc = usable_reg;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = mem_rdata;
        if (state_reg == S_FMT)
        begin
            mem_we = 1'b1;
            for (int k = 0; k < WORD_W; k++)
            begin
                mem_wdata[k] = (base + IW'(k)) < reserve_reg;
            end
        end
        else if (state_reg == S_WR)
        begin
            mem_we = 1'b1;
            for (int k = 0; k < WORD_W; k++)
            begin
                if ((base + IW'(k)) >= first_reg && (base + IW'(k)) < end_reg)
                begin
                    mem_wdata[k] = set_reg;
                end
            end
        end
    end

    bba_mem #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .WORD_W (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (w_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        len_scan = len_reg;
        hit      = 1'b0;
        stop     = 1'b0;
        hit_run  = '0;
        idx      = '0;
        for (int k = 0; k < STEP; k++)
        begin
            idx = base + IW'(32'(j_reg) * STEP + k);
            if (!hit && !stop)
            begin
                if (idx >= usable_reg)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    if (word_reg[OB'(32'(j_reg) * STEP + k)])
                    begin
                        len_scan = '0;
                    end
                    else
                    begin
                        len_scan = len_scan + 1'b1;
                    end
                    if (len_scan >= count_reg)
                    begin
                        hit     = 1'b1;
                        hit_run = idx + IW'(1) - count_reg;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        set_next     = set_reg;
        report_next  = report_reg;
        first_next   = first_reg;
        end_next     = end_reg;
        count_next   = count_reg;
        usable_next  = usable_reg;
        reserve_next = reserve_reg;
        len_next     = len_reg;
        w_next       = w_reg;
        last_next    = last_reg;
        j_next       = j_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        run_next     = run_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    usable_next = usable_now;
                    first_next  = IW'(start_block);
                    count_next  = IW'(block_count);
                    end_next    = IW'(start_block) + IW'(block_count);
                    set_next    = (operation == OP_ALLOC);
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    run_next    = '0;
                    w_next      = '0;
                    j_next      = '0;
                    len_next    = '0;
                    case (operation)
                        OP_FORMAT:
                        begin
                            state_next = S_DIV;
                        end
                        OP_ALLOC, OP_FREE:
                        begin
                            if (IW'(start_block) + IW'(block_count) > usable_now)
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (block_count == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                w_next     = AW'(IW'(start_block) >> OB);
                                last_next  = AW'((IW'(start_block) + IW'(block_count)
                                                  - IW'(1)) >> OB);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            if (block_count == '0)
                            begin
                                found_next = 1'b1;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FRD;
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    reserve_next = reserve_calc;
                    report_next  = 1'b1;
                    w_next       = '0;
                    state_next   = S_FMT;
                end
            end
            S_FMT:
            begin
                w_next = w_reg + 1'b1;
                if (w_reg == AW'(DEPTH - 1))
                begin
                    w_next     = '0;
                    state_next = S_IDLE;
                    if (report_reg)
                    begin
                        done_next = 1'b1;
                        run_next  = (reserve_reg > IW'(1023)) ? RUN_W'(1023)
                                                              : RUN_W'(reserve_reg);
                    end
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (w_reg == last_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FRD:
            begin
                state_next = S_FLD;
            end
            S_FLD:
            begin
                j_next     = '0;
                state_next = S_FSCAN;
            end
            S_FSCAN:
            begin
                len_next = len_scan;
                if (hit)
                begin
                    found_next = 1'b1;
                    run_next   = RUN_W'(hit_run);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stop || ((j_reg == JW'(NSTEP - 1)) && (w_reg == AW'(DEPTH - 1))))
                begin
                    status_next = ST_NORUN;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (j_reg == JW'(NSTEP - 1))
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_FRD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_FMT;
            report_reg  <= 1'b0;
            reserve_reg <= '0;
            w_reg       <= '0;
            j_reg       <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            report_reg  <= report_next;
            reserve_reg <= reserve_next;
            w_reg       <= w_next;
            j_reg       <= j_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg    <= set_next;
        first_reg  <= first_next;
        end_reg    <= end_next;
        count_reg  <= count_next;
        usable_reg <= usable_next;
        len_reg    <= len_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        run_reg    <= run_next;
        if (state_reg == S_FLD)
        begin
            word_reg <= mem_rdata;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign run_start = run_reg;

endmodule

>>> src/bba_div.sv
// ----------------------------------------------------------------------------
// bba_div
// Restoring divider, one quotient bit per cycle, for the format reservation.
// ----------------------------------------------------------------------------
module bba_div
    import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [BSIZE_W-1:0] divisor,
    output logic               done,
    output logic [TOTAL_W-1:0] quotient
);

    localparam int CNT_W = $clog2(TOTAL_W + 1);

    logic [TOTAL_W-1:0] q_reg, q_next;
    logic [BSIZE_W:0]   r_reg, r_next;
    logic [BSIZE_W-1:0] d_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [BSIZE_W:0]   shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {r_reg[BSIZE_W-1:0], q_reg[TOTAL_W-1]};
        if (go)
        begin
            q_next   = dividend;
            r_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[TOTAL_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[TOTAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TOTAL_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (go)
        begin
            d_reg <= (divisor == '0) ? BSIZE_W'(1) : divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> src/bba_mem.sv
// ----------------------------------------------------------------------------
// bba_mem
// Single-port synchronous map memory with a registered read.
// ----------------------------------------------------------------------------
module bba_mem
    import bba_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int AW     = 5,
    parameter int WORD_W = 32
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     addr,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> bench/bitmap_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Drives format, allocate, free and find commands into the allocator under
// several volume and block size settings, predicts every result beat from a
// shadow copy of the used map, and compares each beat field by field.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_N     = NUM_BLOCKS_DEF;
    localparam int CYC_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [RUN_W-1:0] run;
    } alloc_rsp_t;

    typedef struct {
        op_t              op;
        logic [START_W-1:0] sb;
        logic [COUNT_W-1:0] cnt;
        bit               typed;
        alloc_rsp_t       rsp;
    } cmd_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic [1:0]         operation;
    logic [START_W-1:0] start_block;
    logic [COUNT_W-1:0] block_count;
    logic               done;
    logic [1:0]         status;
    logic               found;
    logic [RUN_W-1:0]   run_start;

    bitmap_block_allocator dut (.*);

    bit                 shadow_map [MAP_N];
    logic [TOTAL_W-1:0] vol_blocks;
    logic [BSIZE_W-1:0] blk_bytes;
    alloc_rsp_t         pending_rsp [$];
    int                 errors;
    int                 cycles;
    int                 send_idle;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("[bitmap_block_allocator] ERROR");
            $finish;
        end
    end

    function automatic alloc_rsp_t predict_alloc(op_t op, logic [START_W-1:0] sb,
                                                 logic [COUNT_W-1:0] cnt);
        alloc_rsp_t r;
        int total;
        int bs;
        int reserve;
        int len;
        r = '0;
        r.status = ST_OK;
        total = (vol_blocks > MAP_N) ? MAP_N : vol_blocks;
        if (op == OP_FORMAT)
        begin
            bs = (blk_bytes == 0) ? 1 : blk_bytes;
            reserve = vol_blocks / bs + 2;
            if (reserve > total)
                reserve = total;
            for (int i = 0; i < MAP_N; i++)
                shadow_map[i] = (i < reserve);
            r.run = (reserve > 1023) ? 10'd1023 : reserve[RUN_W-1:0];
        end
        else if (op == OP_ALLOC || op == OP_FREE)
        begin
            if (int'(sb) + int'(cnt) > total)
                r.status = ST_RANGE;
            else
                for (int i = 0; i < cnt; i++)
                    shadow_map[sb + i] = (op == OP_ALLOC);
        end
        else if (cnt == 0)
        begin
            r.found = 1'b1;
        end
        else
        begin
            len = 0;
            r.status = ST_NORUN;
            for (int i = 0; i < total; i++)
            begin
                len = shadow_map[i] ? 0 : len + 1;
                if (len >= cnt)
                begin
                    r.status = ST_OK;
                    r.found = 1'b1;
                    r.run = RUN_W'(i + 1 - int'(cnt));
                    break;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected beat status=%0d found=%0d run=%0d",
                         $time, status, found, run_start);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t status exp=%0d act=%0d", $time, want.status, status);
                    errors++;
                end
                if (found !== want.found)
                begin
                    $display("%0t found exp=%0d act=%0d", $time, want.found, found);
                    errors++;
                end
                if (run_start !== want.run)
                begin
                    $display("%0t run_start exp=%0d act=%0d", $time, want.run, run_start);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] val);
        wait_drained();
        repeat (40) @(negedge clk);
        while (busy)
            @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_TOTAL)
            vol_blocks = val[TOTAL_W-1:0];
        else
            blk_bytes = val[BSIZE_W-1:0];
    endtask

    task automatic set_volume(int tb, int bs);
        reg_write(3'(4 * REG_TOTAL), tb);
        reg_write(3'(4 * REG_BSIZE), bs);
    endtask

    task automatic issue_cmd(op_t op, logic [START_W-1:0] sb, logic [COUNT_W-1:0] cnt,
                             bit typed, alloc_rsp_t rsp);
        alloc_rsp_t got;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        operation   <= op;
        start_block <= sb;
        block_count <= cnt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        got = predict_alloc(op, sb, cnt);
        if (typed && got != rsp)
        begin
            $display("%0t table row exp=%h predictor=%h", $time, rsp, got);
            errors++;
        end
        pending_rsp.push_back(typed ? rsp : got);
    endtask

    task automatic random_cmd();
        op_t op;
        int  total;
        int  sel;
        logic [START_W-1:0] sb;
        logic [COUNT_W-1:0] cnt;
        total = (vol_blocks > MAP_N) ? MAP_N : vol_blocks;
        sel = $urandom_range(99);
        op = (sel < 3) ? OP_FORMAT : (sel < 40) ? OP_ALLOC : (sel < 70) ? OP_FREE : OP_FIND;
        sb = $urandom;
        cnt = $urandom;
        if ($urandom_range(9) < 7)
        begin
            cnt = $urandom_range(0, (total > 48) ? 48 : total);
            sb = $urandom_range(0, (total > cnt) ? total - cnt : 0);
        end
        else if ($urandom_range(3) == 0)
            cnt = $urandom_range(1000, 2047);
        issue_cmd(op, sb, cnt, 1'b0, '0);
    endtask

    cmd_row_t dir_rows [] = '{
        '{OP_FIND,   10'd0,    11'd1024, 1'b1, '{ST_OK, 1'b1, 10'd0}},
        '{OP_FIND,   10'd0,    11'd1025, 1'b1, '{ST_NORUN, 1'b0, 10'd0}},
        '{OP_FIND,   10'd0,    11'd0,    1'b1, '{ST_OK, 1'b1, 10'd0}},
        '{OP_FORMAT, 10'd0,    11'd0,    1'b1, '{ST_OK, 1'b0, 10'd4}},
        '{OP_FIND,   10'd0,    11'd1,    1'b1, '{ST_OK, 1'b1, 10'd4}},
        '{OP_ALLOC,  10'd1023, 11'd1,    1'b1, '{ST_OK, 1'b0, 10'd0}},
        '{OP_ALLOC,  10'd1023, 11'd2,    1'b1, '{ST_RANGE, 1'b0, 10'd0}},
        '{OP_FREE,   10'd1023, 11'd2047, 1'b1, '{ST_RANGE, 1'b0, 10'd0}},
        '{OP_ALLOC,  10'd500,  11'd0,    1'b1, '{ST_OK, 1'b0, 10'd0}},
        '{OP_FIND,   10'd0,    11'd1020, 1'b1, '{ST_NORUN, 1'b0, 10'd0}},
        '{OP_FIND,   10'd0,    11'd1019, 1'b1, '{ST_OK, 1'b1, 10'd4}},
        '{OP_ALLOC,  10'd4,    11'd100,  1'b0, '0},
        '{OP_FREE,   10'd50,   11'd10,   1'b0, '0},
        '{OP_FIND,   10'd0,    11'd10,   1'b0, '0},
        '{OP_FIND,   10'd0,    11'd11,   1'b0, '0},
        '{OP_FREE,   10'd0,    11'd1024, 1'b0, '0},
        '{OP_FIND,   10'd0,    11'd2047, 1'b1, '{ST_NORUN, 1'b0, 10'd0}},
        '{OP_ALLOC,  10'd0,    11'd1024, 1'b0, '0},
        '{OP_FIND,   10'd0,    11'd1,    1'b1, '{ST_NORUN, 1'b0, 10'd0}},
        '{OP_FREE,   10'd682,  11'd341,  1'b0, '0},
        '{OP_FIND,   10'd0,    11'd341,  1'b0, '0}
    };

    initial
    begin
        errors      = 0;
        cycles      = 0;
        send_idle   = 23;
        vol_blocks  = TOTAL_RST;
        blk_bytes   = BSIZE_RST;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        operation   = OP_FORMAT;
        start_block = '0;
        block_count = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            issue_cmd(dir_rows[i].op, dir_rows[i].sb, dir_rows[i].cnt,
                      dir_rows[i].typed, dir_rows[i].rsp);

        set_volume(0, 0);
        issue_cmd(OP_FORMAT, 10'd0, 11'd0, 1'b1, '{ST_OK, 1'b0, 10'd0});
        issue_cmd(OP_FIND, 10'd0, 11'd0, 1'b1, '{ST_OK, 1'b1, 10'd0});
        issue_cmd(OP_ALLOC, 10'd0, 11'd1, 1'b1, '{ST_RANGE, 1'b0, 10'd0});
        set_volume(2047, 1);
        issue_cmd(OP_FORMAT, 10'd0, 11'd0, 1'b1, '{ST_OK, 1'b0, 10'd1023});
        issue_cmd(OP_FIND, 10'd0, 11'd1, 1'b1, '{ST_NORUN, 1'b0, 10'd0});
        set_volume(1024, 8191);
        issue_cmd(OP_FORMAT, 10'd0, 11'd0, 1'b1, '{ST_OK, 1'b0, 10'd2});

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_volume(1024, 512);
                1: set_volume($urandom_range(1, 1024), $urandom_range(1, 64));
                2: set_volume(2047, 4096);
                3: set_volume($urandom_range(1, 200), 0);
                4: set_volume(1, 1);
                default: set_volume($urandom_range(1, 2047), $urandom_range(1, 8191));
            endcase
            send_idle = (ph < 2) ? 23 : (ph < 4) ? 83 : 0;
            issue_cmd(OP_FORMAT, 10'd0, 11'd0, 1'b0, '0);
            for (int n = 0; n < 158; n++)
            begin
                random_cmd();
                if (n == 80)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("[bitmap_block_allocator] OK");
        else
            $display("[bitmap_block_allocator] ERROR");
        $finish;
    end
endmodule

>>> bitmap_block_allocator.f
src/bba_pkg.sv
src/bba_div.sv
src/bba_mem.sv
src/bitmap_block_allocator.sv
bench/bitmap_block_allocator_tb.sv
